// File: sv/websocket_frame_deframer_unit_macros.svh
// Assertion macros used by the checker file of the deframer.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/wsfd_pkg.sv
`default_nettype none

package wsfd_pkg;

    // Width of the decoded frame length register (16 to 64).
    localparam int LEN_BITS = 64;

    localparam int MAX_LEN_W    = 32;
    localparam int FRAME_LEN_W  = 63;
    localparam int KIND_W       = 2;
    localparam int TDATA_W      = 80;

    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 32'd65536;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVERSIZE = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [7:0]             payload_byte;
        logic [3:0]             opcode;
        logic                   fin;
        logic                   last_of_frame;
        logic [FRAME_LEN_W-1:0] frame_length;
    } result_t;

endpackage

`default_nettype wire

// File: sv/wsfd_parse.sv
`default_nettype none

module wsfd_parse (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             step,
    input  wire logic [7:0]                       data_byte,
    input  wire logic [wsfd_pkg::MAX_LEN_W-1:0]   max_len,
    output logic                                  res_valid,
    output wsfd_pkg::result_t                     res
);

    typedef enum logic [2:0] {
        PH_HEAD0,
        PH_HEAD1,
        PH_EXT,
        PH_MASK,
        PH_DATA
    } phase_t;

    phase_t                               phase_reg, phase_next;
    logic [2:0]                           count_reg, count_next;
    logic                                 ext_long_reg, ext_long_next;
    logic [wsfd_pkg::LEN_BITS-1:0]        len_reg, len_next;
    logic                                 ovf_reg, ovf_next;
    logic [31:0]                          key_reg, key_next;
    logic [1:0]                           key_idx_reg, key_idx_next;
    logic [wsfd_pkg::MAX_LEN_W-1:0]       remain_reg, remain_next;
    logic                                 fin_reg, fin_next;
    logic [3:0]                           opcode_reg, opcode_next;

    logic [63:0]                          len_ext;
    logic                                 oversize;
    logic [7:0]                           key_byte;

    assign len_ext  = 64'(len_reg);
    assign oversize = ovf_reg || (len_ext > 64'(max_len));

    // Key bytes are used most significant first.
    always_comb begin
        case (key_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        ext_long_next = ext_long_reg;
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        key_next      = key_reg;
        key_idx_next  = key_idx_reg;
        remain_next   = remain_reg;
        fin_next      = fin_reg;
        opcode_next   = opcode_reg;

        res_valid         = 1'b0;
        res.kind          = wsfd_pkg::KIND_PAYLOAD;
        res.payload_byte  = 8'd0;
        res.opcode        = opcode_reg;
        res.fin           = fin_reg;
        res.last_of_frame = 1'b1;
        res.frame_length  = len_ext[wsfd_pkg::FRAME_LEN_W-1:0];

        case (phase_reg)
            PH_HEAD0: begin
                fin_next    = data_byte[7];
                opcode_next = data_byte[3:0];
                len_next    = '0;
                key_next    = '0;
                count_next  = '0;
                ovf_next    = 1'b0;
                phase_next  = PH_HEAD1;
            end
            PH_HEAD1: begin
                count_next    = '0;
                ext_long_next = (data_byte[6:0] == wsfd_pkg::LEN_CODE_EXT64);
                if (data_byte[6:0] < wsfd_pkg::LEN_CODE_EXT16) begin
                    len_next   = wsfd_pkg::LEN_BITS'(data_byte[6:0]);
                    phase_next = PH_MASK;
                end else begin
                    len_next   = '0;
                    phase_next = PH_EXT;
                end
            end
            PH_EXT: begin
                if (len_reg[wsfd_pkg::LEN_BITS-1 -: 8] != 8'd0) begin
                    ovf_next = 1'b1;
                end
                len_next = {len_reg[wsfd_pkg::LEN_BITS-9:0], data_byte};
                if (count_reg == (ext_long_reg ? 3'd7 : 3'd1)) begin
                    count_next = '0;
                    phase_next = PH_MASK;
                end else begin
                    count_next = count_reg + 3'd1;
                end
            end
            PH_MASK: begin
                key_next = {key_reg[23:0], data_byte};
                if (count_reg < 3'd3) begin
                    count_next = count_reg + 3'd1;
                end else begin
                    count_next   = '0;
                    key_idx_next = '0;
                    remain_next  = len_ext[wsfd_pkg::MAX_LEN_W-1:0];
                    if (oversize) begin
                        res_valid  = 1'b1;
                        res.kind   = wsfd_pkg::KIND_OVERSIZE;
                        phase_next = PH_HEAD0;
                    end else if (len_ext == 64'd0) begin
                        res_valid  = 1'b1;
                        res.kind   = wsfd_pkg::KIND_EMPTY;
                        phase_next = PH_HEAD0;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                // A frame reaches this phase only with a length that fits
                // the 32-bit limit, so a 32-bit down count marks its end.
                res_valid         = 1'b1;
                res.payload_byte  = data_byte ^ key_byte;
                res.last_of_frame = (remain_reg == wsfd_pkg::MAX_LEN_W'(1));
                key_idx_next      = key_idx_reg + 2'd1;
                remain_next       = remain_reg - wsfd_pkg::MAX_LEN_W'(1);
                if (remain_reg == wsfd_pkg::MAX_LEN_W'(1)) begin
                    phase_next = PH_HEAD0;
                end
            end
            default: begin
                phase_next = PH_HEAD0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEAD0;
            count_reg    <= '0;
            ext_long_reg <= 1'b0;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            key_reg      <= '0;
            key_idx_reg  <= '0;
            remain_reg   <= '0;
            fin_reg      <= 1'b0;
            opcode_reg   <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            ext_long_reg <= ext_long_next;
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            key_reg      <= key_next;
            key_idx_reg  <= key_idx_next;
            remain_reg   <= remain_next;
            fin_reg      <= fin_next;
            opcode_reg   <= opcode_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/websocket_frame_deframer_unit.sv
// WebSocket frame deframer with payload unmasking.
// The s_ channel carries the received byte stream, one byte per request in
// s_tdata. Each frame is a two-byte header, 0, 2 or 8 big-endian extended
// length bytes, a 4-byte mask key and the payload. Every payload byte leaves
// on the m_ channel unmasked, with the frame's opcode, FIN bit and length.
// An empty frame gives one request of kind "empty" and a frame longer than
// the configured limit gives one request of kind "oversize", both at the last
// mask key byte; the kind travels in m_tuser and the frame end in m_tlast.
// The limit is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while the block idles, as the block itself does not enforce this. A
// byte is held in the input register and then parsed into the result register,
// from which its result is offered on the m_ channel. Throughput is one byte
// per cycle while no result is stalled by m_tready. When m_tready is low the
// result register holds its request, the input register still takes a byte if
// it is empty, and then s_tready falls until the result is taken. Synchronous
// active-low reset empties both registers, returns the parser to the first
// header byte and sets the limit to 65536.

`default_nettype none

module websocket_frame_deframer_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [wsfd_pkg::MAX_LEN_W-1:0]     cfg_wr_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [7:0] data_byte
    input  wire logic [7:0]                         s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [7:0] payload_byte, [11:8] opcode, [12] fin, [75:13] frame_length,
    // [79:76] zero
    output logic [wsfd_pkg::TDATA_W-1:0]            m_tdata,
    // [1:0] kind
    output logic [wsfd_pkg::KIND_W-1:0]             m_tuser,
    output logic                                    m_tlast
);

    logic [wsfd_pkg::MAX_LEN_W-1:0] max_len_reg;

    logic                           in_valid_reg;
    logic [7:0]                     in_byte_reg;

    logic                           out_valid_reg;
    wsfd_pkg::result_t              out_res_reg;

    logic                           out_free;
    logic                           step;
    logic                           res_valid;
    wsfd_pkg::result_t              res;

    // The result register frees up when it is empty or being taken; the
    // parser steps whenever a byte waits and its result has a place to go.
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= wsfd_pkg::MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    wsfd_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (in_byte_reg),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register. Header, length and key bytes step the parser without
    // producing a request, but for the last key byte of an empty or oversize frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.last_of_frame;
    assign m_tdata  = {4'd0, out_res_reg.frame_length, out_res_reg.fin,
                       out_res_reg.opcode, out_res_reg.payload_byte};

endmodule

`default_nettype wire

// File: sv/wsfd_checker.sv
`default_nettype none

`include "websocket_frame_deframer_unit_macros.svh"

module wsfd_checker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [wsfd_pkg::TDATA_W-1:0]       m_tdata,
    input  wire logic [wsfd_pkg::KIND_W-1:0]        m_tuser,
    input  wire logic                               m_tlast
);

    logic ctrl_request;

    assign ctrl_request = m_tvalid && (m_tuser != wsfd_pkg::KIND_PAYLOAD);

    `WSFD_ASSERT_NXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "stalled result request changed")

    `WSFD_ASSERT_IMP(a_ctrl_ends_frame, aclk, aresetn, ctrl_request, m_tlast,
        "empty or oversize request without frame end")

    `WSFD_ASSERT_IMP(a_ctrl_no_byte, aclk, aresetn, ctrl_request, m_tdata[7:0] == 8'd0,
        "empty or oversize request carries a payload byte")

    `WSFD_ASSERT_IMP(a_reset_empty, aclk, 1'b1, $past(!aresetn), !m_tvalid,
        "result request valid right after reset")

endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (.*);

`default_nettype wire
